### design/vt4x4_pkg.sv
// ----------------------------------------------------------------------------
// vt4x4_pkg: shared types and constants of the vector transform engine
// Field widths, operation codes and the transaction payload that moves
// along the chain of cells.
// ----------------------------------------------------------------------------
package vt4x4_pkg;

    localparam int VEC_N  = 4;
    localparam int WORD_W = 32;
    localparam int PROD_W = 64;
    localparam int IDX_W  = 2;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ROW  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [MODE_W-1:0]            mode;
        logic [IDX_W-1:0]             row_index;
        logic [IDX_W-1:0]             col_index;
        logic [WORD_W-1:0]            element_value;
        logic [VEC_N-1:0][WORD_W-1:0] vec;
    } item_t;

endpackage

### design/vt4x4_cell.sv
// ----------------------------------------------------------------------------
// vt4x4_cell: one cell of the transform chain
// Holds row K and column K of the matrix, multiplies vector component K by
// one of them, as the mode selects, and adds the shifted products to the running sums of the transaction.
// ----------------------------------------------------------------------------
module vt4x4_cell #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16,
    parameter int ACC_W     = 50,
    parameter int K         = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  vt4x4_pkg::item_t              in_item,
    input  logic [DIM-1:0][ACC_W-1:0]     in_acc,
    output logic                          out_valid,
    input  logic                          out_ready,
    output vt4x4_pkg::item_t              out_item,
    output logic [DIM-1:0][ACC_W-1:0]     out_acc
);

    localparam int SH_W = vt4x4_pkg::PROD_W - FRAC_BITS;

    logic [DIM-1:0][vt4x4_pkg::WORD_W-1:0] row_reg, row_next;
    logic [DIM-1:0][vt4x4_pkg::WORD_W-1:0] col_reg, col_next;
    logic [DIM-1:0][vt4x4_pkg::WORD_W-1:0] m_sel;
    logic [vt4x4_pkg::WORD_W-1:0]          vk;

    logic                                   mid_valid_reg, mid_valid_next;
    vt4x4_pkg::item_t                       mid_item_reg;
    logic [DIM-1:0][ACC_W-1:0]              mid_acc_reg;
    logic [DIM-1:0][vt4x4_pkg::PROD_W-1:0]  prod_reg, prod_next;

    logic                                   out_valid_reg, out_valid_next;
    vt4x4_pkg::item_t                       out_item_reg;
    logic [DIM-1:0][ACC_W-1:0]              out_acc_reg, out_acc_next;

    logic out_adv;
    logic mid_adv;
    logic in_take;

    if (K < vt4x4_pkg::VEC_N) begin : g_vec
        assign vk = in_item.vec[K];
    end else begin : g_novec
        assign vk = '0;
    end

    assign out_adv  = !out_valid_reg || out_ready;
    assign mid_adv  = mid_valid_reg && out_adv;
    assign in_ready = !mid_valid_reg || out_adv;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (in_take && in_item.mode == vt4x4_pkg::MODE_LOAD)
        begin
            for (int j = 0; j < DIM; j++)
            begin
                if (int'(in_item.row_index) == K && int'(in_item.col_index) == j)
                begin
                    row_next[j] = in_item.element_value;
                end
                if (int'(in_item.col_index) == K && int'(in_item.row_index) == j)
                begin
                    col_next[j] = in_item.element_value;
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < DIM; j++)
        begin
            m_sel[j] = (in_item.mode == vt4x4_pkg::MODE_COL) ? col_reg[j] : row_reg[j];
            prod_next[j] = $signed({{32{m_sel[j][31]}}, m_sel[j]})
                         * $signed({{32{vk[31]}}, vk});
        end
    end

    always_comb
    begin
        for (int j = 0; j < DIM; j++)
        begin
            out_acc_next[j] = mid_acc_reg[j]
                + {{(ACC_W - SH_W){prod_reg[j][vt4x4_pkg::PROD_W-1]}},
                   prod_reg[j][vt4x4_pkg::PROD_W-1:FRAC_BITS]};
        end
    end

    always_comb
    begin
        mid_valid_next = mid_valid_reg;
        if (in_ready)
        begin
            mid_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg;
        if (out_adv)
        begin
            out_valid_next = mid_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mid_item_reg <= in_item;
            mid_acc_reg  <= in_acc;
            prod_reg     <= prod_next;
        end
        if (mid_adv)
        begin
            out_item_reg <= mid_item_reg;
            out_acc_reg  <= out_acc_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_acc   = out_acc_reg;

endmodule

### design/vt4x4_out.sv
// ----------------------------------------------------------------------------
// vt4x4_out: saturation and output register
// Clips the finished sums to 32 bits, sets the saturation flag and holds the
// result until it is taken; load transactions are dropped here.
// ----------------------------------------------------------------------------
module vt4x4_out #(
    parameter int DIM   = 4,
    parameter int ACC_W = 50
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  vt4x4_pkg::item_t                            in_item,
    input  logic [DIM-1:0][ACC_W-1:0]                   in_acc,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [vt4x4_pkg::VEC_N-1:0][vt4x4_pkg::WORD_W-1:0] out_comp,
    output logic                                        out_sat
);

    logic [vt4x4_pkg::VEC_N-1:0][vt4x4_pkg::WORD_W-1:0] comp_next, comp_reg;
    logic [vt4x4_pkg::VEC_N-1:0]                        sat_bits;
    logic                                                sat_reg;
    logic                                                valid_reg, valid_next;
    logic                                                is_load;
    logic                                                free;

    for (genvar j = 0; j < vt4x4_pkg::VEC_N; j++) begin : g_comp
        if (j < DIM) begin : g_live
            logic in_range;
            assign in_range = (in_acc[j][ACC_W-1:31] == '0)
                           || (in_acc[j][ACC_W-1:31] == '1);
            assign sat_bits[j]  = !in_range;
            assign comp_next[j] = in_range ? in_acc[j][31:0]
                                : (in_acc[j][ACC_W-1] ? vt4x4_pkg::WORD_MIN
                                                      : vt4x4_pkg::WORD_MAX);
        end else begin : g_dead
            assign sat_bits[j]  = 1'b0;
            assign comp_next[j] = '0;
        end
    end

    assign is_load  = in_item.mode == vt4x4_pkg::MODE_LOAD;
    assign free     = !valid_reg || out_ready;
    assign in_ready = is_load || free;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = in_valid && !is_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && in_valid && !is_load)
        begin
            comp_reg <= comp_next;
            sat_reg  <= |sat_bits;
        end
    end

    assign out_valid = valid_reg;
    assign out_comp  = comp_reg;
    assign out_sat   = sat_reg;

endmodule

### design/vector_transform_4x4_top.sv
// ----------------------------------------------------------------------------
// vector_transform_4x4_top: matrix and vector transform engine
// A chain of DIM cells forms the column or row vector product with a stored
// signed Q16.16 matrix, followed by a saturating output register.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: mode; tdata: indices, element, vector
//   m_axis    out        tuser: saturated; tdata: four result components
//
// One transaction is taken in every cycle while the chain is not held by a
// stall at the output; each cell has a multiply stage and an accumulate
// stage, and the output register follows the accumulate stage of the last
// cell. Loads and unused modes give no result.
// Reset clears the matrix to zero and empties every stage at once.
// A stall at the output fills the empty stages of the chain before the
// input is held.
// ----------------------------------------------------------------------------
module vector_transform_4x4_top #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] row_index, [3:2] col_index, [35:4] element_value, [67:36] vec_x,
    // [99:68] vec_y, [131:100] vec_z, [163:132] vec_w, [167:164] zero
    input  logic [167:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] out_x, [63:32] out_y, [95:64] out_z, [127:96] out_w
    output logic [127:0] m_axis_tdata,
    // [0] saturated
    output logic [0:0]   m_axis_tuser
);

    localparam int ACC_W = vt4x4_pkg::PROD_W - FRAC_BITS + $clog2(DIM);

    logic                      c_valid [DIM+1];
    logic                      c_ready [DIM+1];
    vt4x4_pkg::item_t          c_item  [DIM+1];
    logic [DIM-1:0][ACC_W-1:0] c_acc   [DIM+1];

    logic [vt4x4_pkg::VEC_N-1:0][vt4x4_pkg::WORD_W-1:0] res;
    logic                                               drop;

    assign drop = s_axis_tuser == vt4x4_pkg::MODE_NONE;

    assign c_item[0].mode          = s_axis_tuser;
    assign c_item[0].row_index     = s_axis_tdata[1:0];
    assign c_item[0].col_index     = s_axis_tdata[3:2];
    assign c_item[0].element_value = s_axis_tdata[35:4];
    assign c_item[0].vec[0]        = s_axis_tdata[67:36];
    assign c_item[0].vec[1]        = s_axis_tdata[99:68];
    assign c_item[0].vec[2]        = s_axis_tdata[131:100];
    assign c_item[0].vec[3]        = s_axis_tdata[163:132];
    assign c_acc[0]                = '0;
    assign c_valid[0]              = s_axis_tvalid && !drop;
    assign s_axis_tready           = drop || c_ready[0];

    for (genvar k = 0; k < DIM; k++) begin : g_cell
        vt4x4_cell #(
            .DIM       (DIM),
            .FRAC_BITS (FRAC_BITS),
            .ACC_W     (ACC_W),
            .K         (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[k]),
            .in_ready  (c_ready[k]),
            .in_item   (c_item[k]),
            .in_acc    (c_acc[k]),
            .out_valid (c_valid[k+1]),
            .out_ready (c_ready[k+1]),
            .out_item  (c_item[k+1]),
            .out_acc   (c_acc[k+1])
        );
    end

    vt4x4_out #(
        .DIM   (DIM),
        .ACC_W (ACC_W)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid[DIM]),
        .in_ready  (c_ready[DIM]),
        .in_item   (c_item[DIM]),
        .in_acc    (c_acc[DIM]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_comp  (res),
        .out_sat   (m_axis_tuser[0])
    );

    assign m_axis_tdata = res;

endmodule

### design/vt4x4_checker.sv
// ----------------------------------------------------------------------------
// vt4x4_checker: port checks for the vector transform engine
// Watches the top level's ports and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
module vt4x4_checker #(
    parameter int DIM = 4
) (
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // The saturation flag is only raised with a clipped component.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000
         || m_axis_tdata[63:32] == 32'h7FFF_FFFF || m_axis_tdata[63:32] == 32'h8000_0000
         || m_axis_tdata[95:64] == 32'h7FFF_FFFF || m_axis_tdata[95:64] == 32'h8000_0000
         || m_axis_tdata[127:96] == 32'h7FFF_FFFF || m_axis_tdata[127:96] == 32'h8000_0000)
        else $error("saturation flag without a clipped component");

    // The z and w components beyond the matrix size read as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (DIM > 2 || m_axis_tdata[95:64] == 32'd0)
         && (DIM > 3 || m_axis_tdata[127:96] == 32'd0))
        else $error("unused result component is not zero");

    // No result leaves the block in the first cycle after reset.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result present straight after reset");

endmodule

bind vector_transform_4x4_top vt4x4_checker #(.DIM(DIM)) u_vt4x4_checker (.*);
